>>> hw/rtl/cts_pkg.sv
// Shared types, constants and character helpers for the charset scanner.
`timescale 1ns / 1ps

package cts_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int OUT_BITS        = 16;
    localparam int BYTE_BITS       = 8;
    localparam int MATCH_LEN       = 6;
    localparam int MATCH_IDX_BITS  = $clog2(MATCH_LEN);

    localparam logic [BYTE_BITS-1:0] CH_NUL  = 8'h00;
    localparam logic [BYTE_BITS-1:0] CH_C    = 8'h63;
    localparam logic [BYTE_BITS-1:0] CH_EQ   = 8'h3D;
    localparam logic [BYTE_BITS-1:0] CH_SEMI = 8'h3B;
    localparam logic [BYTE_BITS-1:0] CH_DQ   = 8'h22;
    localparam logic [BYTE_BITS-1:0] CH_SQ   = 8'h27;

    typedef enum logic [7:0] {
        PH_SEARCH   = 8'b0000_0001,
        PH_MATCH    = 8'b0000_0010,
        PH_PRE_EQ   = 8'b0000_0100,
        PH_POST_EQ  = 8'b0000_1000,
        PH_Q_LEAD   = 8'b0001_0000,
        PH_Q_BODY   = 8'b0010_0000,
        PH_UNQUOTED = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic                found;
        logic [OUT_BITS-1:0] value_start;
        logic [OUT_BITS-1:0] value_end;
        logic [OUT_BITS-1:0] total_length;
        logic                length_overflow;
    } t_result;

    // Letters that follow the leading c of "charset".
    function automatic logic [BYTE_BITS-1:0] word_tail(input logic [MATCH_IDX_BITS-1:0] idx);
        logic [BYTE_BITS-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h68;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h72;
            3'd3:    ch = 8'h73;
            3'd4:    ch = 8'h65;
            3'd5:    ch = 8'h74;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [BYTE_BITS-1:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0C) || (b == 8'h0D);
    endfunction

    // ASCII upper case to lower case, everything else unchanged.
    function automatic logic [BYTE_BITS-1:0] fold(input logic [BYTE_BITS-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
    endfunction

endpackage

>>> hw/rtl/cts_ifs.sv
// Valid/ready channel interfaces for the input byte stream and the scan result.
`timescale 1ns / 1ps

interface cts_byte_if;
    logic                          valid;
    logic                          ready;
    logic [cts_pkg::BYTE_BITS-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface cts_result_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [cts_pkg::OUT_BITS-1:0] value_start;
    logic [cts_pkg::OUT_BITS-1:0] value_end;
    logic [cts_pkg::OUT_BITS-1:0] total_length;
    logic                         length_overflow;

    modport source (output valid, output found, output value_start, output value_end,
                    output total_length, output length_overflow, input ready);
    modport sink   (input valid, input found, input value_start, input value_end,
                    input total_length, input length_overflow, output ready);
endinterface

>>> hw/rtl/cts_scan_core.sv
// Scanner state machine: position counter, charset match and value offsets.
`timescale 1ns / 1ps

module cts_scan_core #(
    parameter int OFFSET_BITS = cts_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [cts_pkg::BYTE_BITS-1:0] i_data_byte,
    output cts_pkg::t_result              o_result,
    output logic                          o_last
);
    import cts_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;

    t_phase                    r_phase, n_phase;
    logic [MATCH_IDX_BITS-1:0] r_match_idx, n_match_idx;
    logic                      r_quote_sq, n_quote_sq;
    logic [OFFSET_BITS-1:0]    r_pos, n_pos;
    logic [OFFSET_BITS-1:0]    r_start, n_start;
    logic [OFFSET_BITS-1:0]    r_end, n_end;
    logic                      r_ovf, n_ovf;

    logic                      w_ws;
    logic                      w_is_c;
    logic                      w_q_hit;
    logic                      w_at_limit;
    logic [OFFSET_BITS-1:0]    w_pos_inc;
    logic                      w_found;
    logic [OFFSET_BITS-1:0]    w_end_sel;
    t_phase                    w_restart;

    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [OFFSET_BITS-1:0] v);
        return ((v >> OUT_BITS) != '0) ? '1 : OUT_BITS'(v);
    endfunction

    assign o_last     = (i_data_byte == CH_NUL);
    assign w_ws       = is_ws(i_data_byte);
    assign w_is_c     = (fold(i_data_byte) == CH_C);
    assign w_q_hit    = (i_data_byte == (r_quote_sq ? CH_SQ : CH_DQ));
    assign w_at_limit = (r_pos == POS_LIMIT);
    assign w_pos_inc  = w_at_limit ? POS_LIMIT : (r_pos + 1'b1);
    assign w_restart  = w_is_c ? PH_MATCH : PH_SEARCH;

    assign w_found   = (r_phase == PH_DONE) || (r_phase == PH_UNQUOTED);
    assign w_end_sel = (r_phase == PH_UNQUOTED) ? r_pos : r_end;

    always_comb begin
        o_result.found           = w_found;
        o_result.value_start     = w_found ? clamp_out(r_start) : '0;
        o_result.value_end       = w_found ? clamp_out(w_end_sel) : '0;
        o_result.total_length    = clamp_out(r_pos);
        o_result.length_overflow = r_ovf || ((r_pos >> OUT_BITS) != '0);
    end

    always_comb begin
        n_phase     = r_phase;
        n_match_idx = r_match_idx;
        n_quote_sq  = r_quote_sq;
        n_start     = r_start;
        n_end       = r_end;
        n_pos       = w_pos_inc;
        n_ovf       = r_ovf | w_at_limit;

        if (o_last) begin
            // End of string: clear for the next one.
            n_phase     = PH_SEARCH;
            n_match_idx = '0;
            n_quote_sq  = 1'b0;
            n_start     = '0;
            n_end       = '0;
            n_pos       = '0;
            n_ovf       = 1'b0;
        end else begin
            unique case (r_phase)
                PH_SEARCH: begin
                    n_phase     = w_restart;
                    n_match_idx = '0;
                end
                PH_MATCH: begin
                    if (fold(i_data_byte) == word_tail(r_match_idx)) begin
                        n_match_idx = r_match_idx + 1'b1;
                        if (r_match_idx == MATCH_IDX_BITS'(MATCH_LEN - 1)) begin
                            n_phase = PH_PRE_EQ;
                        end
                    end else begin
                        n_phase     = w_restart;
                        n_match_idx = '0;
                    end
                end
                PH_PRE_EQ: begin
                    if (!w_ws) begin
                        if (i_data_byte == CH_EQ) begin
                            n_phase = PH_POST_EQ;
                        end else begin
                            n_phase     = w_restart;
                            n_match_idx = '0;
                        end
                    end
                end
                PH_POST_EQ: begin
                    if (!w_ws) begin
                        if ((i_data_byte == CH_DQ) || (i_data_byte == CH_SQ)) begin
                            n_quote_sq = (i_data_byte == CH_SQ);
                            n_phase    = PH_Q_LEAD;
                        end else begin
                            n_start = r_pos;
                            if (i_data_byte == CH_SEMI) begin
                                n_end   = r_pos;
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_UNQUOTED;
                            end
                        end
                    end
                end
                PH_Q_LEAD: begin
                    // First non-blank byte inside the quotes opens the value.
                    if (!w_ws) begin
                        n_start = r_pos;
                        if (w_q_hit) begin
                            n_end   = r_pos;
                            n_phase = PH_DONE;
                        end else begin
                            n_end   = w_pos_inc;
                            n_phase = PH_Q_BODY;
                        end
                    end
                end
                PH_Q_BODY: begin
                    if (w_q_hit) begin
                        n_phase = PH_DONE;
                    end else if (!w_ws) begin
                        n_end = w_pos_inc;
                    end
                end
                PH_UNQUOTED: begin
                    if (w_ws || (i_data_byte == CH_SEMI)) begin
                        n_end   = r_pos;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_match_idx <= '0;
            r_quote_sq  <= 1'b0;
            r_pos       <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_ovf       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_match_idx <= n_match_idx;
            r_quote_sq  <= n_quote_sq;
            r_pos       <= n_pos;
            r_start     <= n_start;
            r_end       <= n_end;
            r_ovf       <= n_ovf;
        end
    end

endmodule

>>> hw/rtl/content_type_charset_scanner.sv
// A byte is registered at acceptance and scanned when it leaves the input register; the result
// for a zero byte is loaded into the result register when the core scans it.
// Throughput: one byte per cycle, but
// a terminator waits in the input register only while an earlier result is not taken.
// Reset: synchronous, active low; clears the scanner state and both channel valids.
// Top level: input register, scan core, result register.
`timescale 1ns / 1ps

module content_type_charset_scanner #(
    parameter int OFFSET_BITS = cts_pkg::OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cts_byte_if.sink            i_byte,
    cts_result_if.source        o_result
);
    import cts_pkg::*;

    logic                 r_in_vld;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic                 r_out_vld;
    t_result              r_out;

    t_result              w_result;
    logic                 w_last;
    logic                 w_out_free;
    logic                 w_advance;

    assign w_out_free = !r_out_vld || o_result.ready;
    // Hold a terminator until the result register can take its item.
    assign w_advance  = r_in_vld && (!w_last || w_out_free);
    assign i_byte.ready = !r_in_vld || w_advance;

    cts_scan_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_data_byte (r_in_byte),
        .o_result    (w_result),
        .o_last      (w_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance && w_last) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_last) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.found           = r_out.found;
    assign o_result.value_start     = r_out.value_start;
    assign o_result.value_end       = r_out.value_end;
    assign o_result.total_length    = r_out.total_length;
    assign o_result.length_overflow = r_out.length_overflow;

endmodule

>>> hw/rtl/cts_checker.sv
// Port-level checks on the scanner result channel, bound to the top level.
`timescale 1ns / 1ps

module cts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_found,
    input logic [cts_pkg::OUT_BITS-1:0] i_value_start,
    input logic [cts_pkg::OUT_BITS-1:0] i_value_end,
    input logic [cts_pkg::OUT_BITS-1:0] i_total_length,
    input logic                         i_length_overflow
);

    // A stalled result item keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_found)
            && $stable(i_value_start) && $stable(i_value_end)
            && $stable(i_total_length) && $stable(i_length_overflow)))
        else $error("result item changed while stalled");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_value_start == '0 && i_value_end == '0))
        else $error("offsets nonzero without a value");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |->
            (i_value_start <= i_value_end && i_value_end <= i_total_length))
        else $error("value offsets out of order");

endmodule

bind content_type_charset_scanner cts_checker u_cts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_found           (o_result.found),
    .i_value_start     (o_result.value_start),
    .i_value_end       (o_result.value_end),
    .i_total_length    (o_result.total_length),
    .i_length_overflow (o_result.length_overflow)
);

>>> tb/charset_scan_checker.sv
// Checker for the charset scanner: watches both channels, predicts each report and compares it.
`timescale 1ns / 1ps

module charset_scan_checker
    import cts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cts_byte_if   i_byte,
    cts_result_if i_result,
    output int    o_fail_count,
    output int    o_pending
);

    localparam longint      POS_MAX = (longint'(1) << OFFSET_BITS_DEF) - 1;
    localparam longint      OUT_MAX = (longint'(1) << OUT_BITS) - 1;
    localparam logic [55:0] KEYWORD = "charset";
    localparam int          TAIL_LEN = 6;

    t_phase  phase         = PH_SEARCH;
    int      tail_idx      = 0;
    logic    single_quoted = 1'b0;
    longint  scan_pos      = 0;
    longint  value_first   = 0;
    longint  value_last    = 0;
    logic    pos_saturated = 1'b0;
    t_result reports_due[$];
    int      mismatches    = 0;
    int      pending_q     = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_q;

    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0C || b == 8'h0D;
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic logic [7:0] keyword_char(input int idx);
        return KEYWORD[55 - 8 * idx -: 8];
    endfunction

    function automatic longint clamp_out(input longint v);
        return (v > OUT_MAX) ? OUT_MAX : v;
    endfunction

    function void clear_scan();
        phase         = PH_SEARCH;
        tail_idx      = 0;
        single_quoted = 1'b0;
        scan_pos      = 0;
        value_first   = 0;
        value_last    = 0;
        pos_saturated = 1'b0;
    endfunction

    // A byte that breaks the match may itself open a new one.
    function void restart_search(input logic [7:0] b);
        if (lower_case(b) == CH_C) begin
            phase    = PH_MATCH;
            tail_idx = 0;
        end else begin
            phase = PH_SEARCH;
        end
    endfunction

    function void consume_byte(input logic [7:0] b);
        t_result    rpt;
        longint     p;
        logic [7:0] closing;
        p = scan_pos;
        if (b == CH_NUL) begin
            rpt.found           = (phase == PH_DONE) || (phase == PH_UNQUOTED);
            rpt.value_start     = rpt.found ? OUT_BITS'(clamp_out(value_first)) : '0;
            rpt.value_end       = rpt.found ?
                OUT_BITS'(clamp_out(phase == PH_UNQUOTED ? p : value_last)) : '0;
            rpt.total_length    = OUT_BITS'(clamp_out(p));
            rpt.length_overflow = pos_saturated || (p > OUT_MAX);
            reports_due.push_back(rpt);
            clear_scan();
        end else begin
            case (phase)
                PH_SEARCH: begin
                    restart_search(b);
                end
                PH_MATCH: begin
                    if (tail_idx < TAIL_LEN && lower_case(b) == keyword_char(tail_idx + 1)) begin
                        tail_idx++;
                        if (tail_idx == TAIL_LEN) phase = PH_PRE_EQ;
                    end else begin
                        restart_search(b);
                    end
                end
                PH_PRE_EQ: begin
                    if (!is_blank(b)) begin
                        if (b == CH_EQ) phase = PH_POST_EQ;
                        else restart_search(b);
                    end
                end
                PH_POST_EQ: begin
                    if (!is_blank(b)) begin
                        if (b == CH_DQ || b == CH_SQ) begin
                            single_quoted = (b == CH_SQ);
                            phase         = PH_Q_LEAD;
                        end else begin
                            value_first = p;
                            if (b == CH_SEMI) begin
                                value_last = p;
                                phase      = PH_DONE;
                            end else begin
                                phase = PH_UNQUOTED;
                            end
                        end
                    end
                end
                PH_Q_LEAD, PH_Q_BODY: begin
                    closing = single_quoted ? CH_SQ : CH_DQ;
                    // Skip leading blanks; the first other byte opens the body.
                    if (!(phase == PH_Q_LEAD && is_blank(b))) begin
                        if (phase == PH_Q_LEAD) begin
                            value_first = p;
                            value_last  = p;
                            phase       = PH_Q_BODY;
                        end
                        if (b == closing) phase = PH_DONE;
                        else if (!is_blank(b)) value_last = (p + 1 > POS_MAX) ? POS_MAX : p + 1;
                    end
                end
                PH_UNQUOTED: begin
                    if (b == CH_SEMI || is_blank(b)) begin
                        value_last = p;
                        phase      = PH_DONE;
                    end
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
            if (p >= POS_MAX) begin
                scan_pos      = POS_MAX;
                pos_saturated = 1'b1;
            end else begin
                scan_pos = p + 1;
            end
        end
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            // Take the report first: it always belongs to an earlier terminator.
            if (i_result.valid && i_result.ready) begin
                if (reports_due.size() == 0) begin
                    $error("report with no terminated string outstanding");
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    compare_field("found", 32'(want.found), 32'(i_result.found));
                    compare_field("value_start", 32'(want.value_start),
                                  32'(i_result.value_start));
                    compare_field("value_end", 32'(want.value_end), 32'(i_result.value_end));
                    compare_field("total_length", 32'(want.total_length),
                                  32'(i_result.total_length));
                    compare_field("length_overflow", 32'(want.length_overflow),
                                  32'(i_result.length_overflow));
                end
            end
            if (i_byte.valid && i_byte.ready) consume_byte(i_byte.data_byte);
        end
        pending_q <= reports_due.size();
    end

endmodule

>>> tb/content_type_charset_scanner_tb.sv
// Testbench top for the charset scanner: clock, reset, header stimulus and the verdict.
`timescale 1ns / 1ps

module content_type_charset_scanner_tb;
    import cts_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    int         idle_pct   = 20;
    int         bytes_sent = 0;
    int         random_goal;
    int         fail_count;
    int         pending;
    logic [7:0] header_bytes[$];

    cts_byte_if   byte_ch();
    cts_result_if result_ch();

    content_type_charset_scanner uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    charset_scan_checker scan_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(64'd12_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // Report side: random stall bursts while idling is enabled.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && $urandom_range(0, 99) < idle_pct) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 4))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return "c";
            1: return "C";
            2: return CH_SEMI;
            3: return blank_byte();
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Any non-zero byte that neither ends an unquoted value nor is a quote.
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D ||
               c == CH_SEMI || c == CH_DQ || c == CH_SQ);
        return c;
    endfunction

    function void add_byte(input logic [7:0] b);
        header_bytes.push_back(b);
    endfunction

    function void add_text(input string s);
        for (int i = 0; i < s.len(); i++) header_bytes.push_back(8'(s[i]));
    endfunction

    function void add_blanks(input int n);
        repeat (n) add_byte(blank_byte());
    endfunction

    function void build_random_header();
        string      kw;
        int         form;
        logic [7:0] quote;
        kw = "charset";
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 12)) add_byte(noise_byte());
        end else begin
            repeat ($urandom_range(0, 3)) add_byte(noise_byte());
            for (int i = 0; i < kw.len(); i++) begin
                if ($urandom_range(0, 39) == 0) add_byte(noise_byte());
                else if ($urandom_range(0, 1) == 1) add_byte(8'(kw[i]) - 8'd32);
                else add_byte(8'(kw[i]));
            end
            add_blanks($urandom_range(0, 2));
            add_byte(($urandom_range(0, 11) == 0) ? noise_byte() : CH_EQ);
            add_blanks($urandom_range(0, 2));
            form = $urandom_range(0, 7);
            if (form == 0) begin
                add_byte(CH_SEMI);
            end else if (form <= 3) begin
                repeat ($urandom_range(1, 6)) add_byte(value_char());
                if ($urandom_range(0, 1) == 1) begin
                    add_byte($urandom_range(0, 1) ? CH_SEMI : blank_byte());
                end
            end else if (form <= 6) begin
                quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                add_byte(quote);
                add_blanks($urandom_range(0, 2));
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 7))
                        0, 1: add_byte(blank_byte());
                        2: add_byte(quote ^ (CH_SQ ^ CH_DQ));
                        default: add_byte(value_char());
                    endcase
                end
                add_blanks($urandom_range(0, 2));
                if ($urandom_range(0, 5) != 0) add_byte(quote);
            end
            repeat ($urandom_range(0, 4)) add_byte(noise_byte());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Send the built header and its terminator, then clear the buffer.
    task automatic send_header();
        foreach (header_bytes[i]) send_byte(header_bytes[i]);
        send_byte(CH_NUL);
        header_bytes.delete();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty string.
        send_header();
        // Restart on a repeated c, mixed case, value ended by a semicolon, trailing bytes.
        add_text("cCHARSET=ab;x");
        send_header();
        // All-ones byte, blanks around the equals sign, single quotes with padding.
        add_byte(8'hFF);
        add_text("charset\t=");
        add_byte(8'h0C);
        add_text("'  u 8 '");
        send_header();
        // Unclosed double quote.
        add_text("charset=\"abc");
        send_header();
        // Nothing after the equals sign.
        add_text("charset = \r");
        send_header();
        // Empty unquoted value.
        add_text("charset=;");
        send_header();
        // Quotes holding only blanks, other quote kind inside a body.
        add_text("charset=\" \n\"");
        send_header();
        add_text("charset=\"a'b\"");
        send_header();
        // Broken keyword, then an unquoted value ended by a blank.
        add_text("chacharsetx=1charset=x y");
        send_header();

        random_goal = bytes_sent + 300;
        while (bytes_sent < random_goal) begin
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 4;
                2: idle_pct = 12;
                default: idle_pct = 30;
            endcase
            build_random_header();
            send_header();
        end

        // Final stretch without idling.
        idle_pct = 0;
        repeat (8) begin
            build_random_header();
            send_header();
        end
        byte_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cts_pkg.sv
hw/rtl/cts_ifs.sv
hw/rtl/cts_scan_core.sv
hw/rtl/content_type_charset_scanner.sv
hw/rtl/cts_checker.sv
tb/charset_scan_checker.sv
tb/content_type_charset_scanner_tb.sv
